>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the upscaler RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every clock outside reset
`define EDDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication, checked every clock outside reset
`define EDDU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/eddu_pkg.sv
// Shared constants and types for the edge-directed diagonal upscaler.
// No dependencies.
`default_nettype none

package eddu_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int LW_W     = 10;
  localparam int FH_W     = 13;
  localparam int CFG_W    = 13;
  localparam int PIX_W    = 8;
  localparam int RGB_W    = 3 * PIX_W;
  localparam int NUM_LANE = 3;
  localparam int WIN_SIZE = 16;
  localparam int SUM_W    = 12;
  localparam int NUM_BANK = 3;

  localparam logic [LW_W-1:0] RESET_WIDTH  = LW_W'(512);
  localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(512);

  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic DIR_MAIN = 1'b0;
  localparam logic DIR_ANTI = 1'b1;

  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] chan_win_t;

  typedef struct packed {
    logic ld_sum;
    logic ld_out;
  } lane_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/eddu_ram.sv
// Generic simple dual-port RAM, read-first, registered read data.
// No dependencies.
`default_nettype none

module eddu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/eddu_lane.sv
// One color channel: curvature sums, both diagonal averages, then select.
// Depends on eddu_pkg.
`default_nettype none

module eddu_lane (
  input  wire logic                      clk,
  input  wire eddu_pkg::lane_ctl_t       ctl,
  input  wire eddu_pkg::chan_win_t       win,
  output logic [eddu_pkg::PIX_W-1:0]     val,
  output logic                           dir
);
  import eddu_pkg::*;

  logic [SUM_W-1:0] pos1, pos2, neg1, neg2;
  logic [SUM_W-1:0] s1_next, s2_next;
  logic [PIX_W:0]   main_sum, anti_sum;
  logic [SUM_W-1:0] s1, s2;
  logic [PIX_W-1:0] main_avg, anti_avg;

  // window index is (dy+1)*4 + (dx+1)
  always_comb begin
    pos1 = SUM_W'(win[8]) + SUM_W'(win[5]) + SUM_W'(win[2])
         + SUM_W'(win[13]) + SUM_W'(win[10]) + SUM_W'(win[7]);
    pos2 = SUM_W'(win[1]) + SUM_W'(win[6]) + SUM_W'(win[11])
         + SUM_W'(win[4]) + SUM_W'(win[9]) + SUM_W'(win[14]);
    anti_sum = {1'b0, win[9]} + {1'b0, win[6]};
    main_sum = {1'b0, win[5]} + {1'b0, win[10]};
    neg1 = (SUM_W'(anti_sum) << 1) + SUM_W'(anti_sum);
    neg2 = (SUM_W'(main_sum) << 1) + SUM_W'(main_sum);
    s1_next = pos1 - neg1;
    s2_next = pos2 - neg2;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      s1       <= s1_next;
      s2       <= s2_next;
      main_avg <= main_sum[PIX_W:1];
      anti_avg <= anti_sum[PIX_W:1];
    end
    if (ctl.ld_out) begin
      if ($signed(s1) < $signed(s2)) begin
        val <= main_avg;
        dir <= DIR_MAIN;
      end else begin
        val <= anti_avg;
        dir <= DIR_ANTI;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/edge_directed_diagonal_upscale.sv
// Edge-directed diagonal 2x upscaler top: raster counters, three line banks,
// 4x4 window, three channel lanes and the output register.
// Center (u,v) passes stages B, C, D and E after the beat of pixel (u+2,v+2).
// One pixel per clock unless stalled; each beat reads all banks, writes one.
// Reset clears counters, registers to 512x512 and all stage valids; line
// banks and window are not cleared. Depends on eddu_pkg, eddu_ram, eddu_lane.
`default_nettype none
`include "assert_macros.svh"

module edge_directed_diagonal_upscale (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic                        wr_index,
  input  wire logic [eddu_pkg::CFG_W-1:0]  wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [eddu_pkg::PIX_W-1:0]  red_in,
  input  wire logic [eddu_pkg::PIX_W-1:0]  green_in,
  input  wire logic [eddu_pkg::PIX_W-1:0]  blue_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [eddu_pkg::COL_W-1:0]       center_col,
  output logic [eddu_pkg::ROW_W-1:0]       center_row,
  output logic [eddu_pkg::PIX_W-1:0]       red_out,
  output logic [eddu_pkg::PIX_W-1:0]       green_out,
  output logic [eddu_pkg::PIX_W-1:0]       blue_out,
  output logic                             red_dir,
  output logic                             green_dir,
  output logic                             blue_dir
);
  import eddu_pkg::*;

  logic [LW_W-1:0]  line_width;
  logic [FH_W-1:0]  frame_height;
  logic [LW_W-1:0]  eff_width;
  logic [FH_W-1:0]  eff_height;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [1:0]       row_slot;
  logic [LW_W-1:0]  col_inc;
  logic [FH_W-1:0]  row_inc;
  logic             accept;

  logic             vb, vc, vd, ve;
  logic             ready_b, ready_c, ready_d, ready_e;
  logic [RGB_W-1:0] cur_b;
  logic [1:0]       slot_b;
  logic             emit_b, emit_c;
  logic [COL_W-1:0] col_b, col_c, col_d;
  logic [ROW_W-1:0] row_b, row_c, row_d;

  logic [RGB_W-1:0] bank_rd [NUM_BANK];
  logic [RGB_W-1:0] col_px  [4];
  logic [WIN_SIZE-1:0][RGB_W-1:0] window_regs;
  chan_win_t        chan_win [NUM_LANE];
  lane_ctl_t        lane_ctl;
  logic [PIX_W-1:0] lane_val [NUM_LANE];
  logic             lane_dir [NUM_LANE];

  // effective frame size
  always_comb begin
    if (line_width == '0) begin
      eff_width = LW_W'(1);
    end else if (line_width > LW_W'(MAX_WIDTH)) begin
      eff_width = LW_W'(MAX_WIDTH);
    end else begin
      eff_width = line_width;
    end
    if (frame_height == '0) begin
      eff_height = FH_W'(1);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      eff_height = FH_W'(MAX_HEIGHT);
    end else begin
      eff_height = frame_height;
    end
    col_inc = {1'b0, col_count} + LW_W'(1);
    row_inc = {1'b0, row_count} + FH_W'(1);
  end

  assign ready_e  = !ve || !out_stall;
  assign ready_d  = !vd || ready_e;
  assign ready_c  = !vc || ready_d;
  assign ready_b  = !vb || ready_c;
  assign in_stall = !ready_b;
  assign accept   = in_valid && ready_b;

  // config and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      col_count    <= '0;
      row_count    <= '0;
      row_slot     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LINE_WIDTH:   line_width   <= wr_data[LW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= wr_data[FH_W-1:0];
        default:          line_width   <= line_width;
      endcase
      col_count <= '0;
      row_count <= '0;
      row_slot  <= '0;
    end else if (accept) begin
      if (col_inc >= eff_width) begin
        col_count <= '0;
        if (row_inc >= eff_height) begin
          row_count <= '0;
          row_slot  <= '0;
        end else begin
          row_count <= row_inc[ROW_W-1:0];
          row_slot  <= (row_slot == 2'd2) ? 2'd0 : row_slot + 2'd1;
        end
      end else begin
        col_count <= col_inc[COL_W-1:0];
      end
    end
  end

  // line banks: read rows r-3..r-1 at column c, overwrite row r-3 with row r
  for (genvar k = 0; k < NUM_BANK; k++) begin : g_bank
    eddu_ram #(
      .WIDTH(RGB_W),
      .DEPTH(MAX_WIDTH)
    ) u_bank (
      .clk  (clk),
      .we   (accept && (row_slot == 2'(k))),
      .waddr(col_count),
      .wdata({blue_in, green_in, red_in}),
      .re   (accept),
      .raddr(col_count),
      .rdata(bank_rd[k])
    );
  end

  // stage B: bank data lands
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= accept;
    end
    if (accept) begin
      cur_b  <= {blue_in, green_in, red_in};
      slot_b <= row_slot;
      emit_b <= (col_count >= COL_W'(3)) && (row_count >= ROW_W'(3));
      col_b  <= col_count - COL_W'(2);
      row_b  <= row_count - ROW_W'(2);
    end
  end

  always_comb begin
    case (slot_b)
      2'd0: begin
        col_px[0] = bank_rd[0];
        col_px[1] = bank_rd[1];
        col_px[2] = bank_rd[2];
      end
      2'd1: begin
        col_px[0] = bank_rd[1];
        col_px[1] = bank_rd[2];
        col_px[2] = bank_rd[0];
      end
      default: begin
        col_px[0] = bank_rd[2];
        col_px[1] = bank_rd[0];
        col_px[2] = bank_rd[1];
      end
    endcase
    col_px[3] = cur_b;
  end

  // stage C: window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (ready_c) begin
      vc <= vb;
    end
    if (vb && ready_c) begin
      for (int y = 0; y < 4; y++) begin
        for (int x = 0; x < 3; x++) begin
          window_regs[y*4+x] <= window_regs[y*4+x+1];
        end
        window_regs[y*4+3] <= col_px[y];
      end
      emit_c <= emit_b;
      col_c  <= col_b;
      row_c  <= row_b;
    end
  end

  // stage D: lane sums; stage E: lane select and output register
  assign lane_ctl.ld_sum = vc && emit_c && ready_d;
  assign lane_ctl.ld_out = vd && ready_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (ready_d) begin
        vd <= vc && emit_c;
      end
      if (ready_e) begin
        ve <= vd;
      end
    end
    if (lane_ctl.ld_sum) begin
      col_d <= col_c;
      row_d <= row_c;
    end
    if (lane_ctl.ld_out) begin
      center_col <= col_d;
      center_row <= row_d;
    end
  end

  for (genvar ch = 0; ch < NUM_LANE; ch++) begin : g_lane
    always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        chan_win[ch][i] = window_regs[i][ch*PIX_W +: PIX_W];
      end
    end

    eddu_lane u_lane (
      .clk(clk),
      .ctl(lane_ctl),
      .win(chan_win[ch]),
      .val(lane_val[ch]),
      .dir(lane_dir[ch])
    );
  end

  assign out_valid = ve;
  assign red_out   = lane_val[0];
  assign green_out = lane_val[1];
  assign blue_out  = lane_val[2];
  assign red_dir   = lane_dir[0];
  assign green_dir = lane_dir[1];
  assign blue_dir  = lane_dir[2];

  `EDDU_ASSERT(a_col_in_range, {1'b0, col_count} < eff_width, "column count past width")
  `EDDU_ASSERT(a_row_in_range, {1'b0, row_count} < eff_height, "row count past height")
  `EDDU_ASSERT(a_slot_legal, row_slot != 2'd3, "row slot out of range")
  `EDDU_ASSERT_IMPL(a_out_interior, ve, (center_col != '0) && (center_row != '0), "border center emitted")

endmodule

`default_nettype wire
